// ----- hw/rtl/cfss_pkg.sv -----
// Package: constants and codes for the coordinate frame to servo/stepper block.
package cfss_pkg;

  localparam logic [7:0]  START_MARK  = 8'hFF;
  localparam logic [8:0]  SERVO_BASE  = 9'd221;
  localparam logic [10:0] X_FULL      = 11'd1920;
  localparam logic [10:0] Y_FULL      = 11'd1080;
  localparam logic [9:0]  STEP_LIMIT  = 10'd623;
  localparam logic [9:0]  STEP_OFFSET = 10'd107;

  // floor(d*47/1920) as (d*SERVO_RECIP) >> 24, exact for d <= 1920
  localparam logic [18:0] SERVO_RECIP = 19'd410693;
  // floor(y*730/1080) as (y*STEP_RECIP) >> 20, exact for y <= 1080
  localparam logic [19:0] STEP_RECIP  = 20'd708761;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_X_HI = 3'd1;
  localparam logic [2:0] PH_X_LO = 3'd2;
  localparam logic [2:0] PH_Y_HI = 3'd3;
  localparam logic [2:0] PH_Y_LO = 3'd4;

endpackage

// ----- hw/rtl/cfss_if.sv -----
// Interfaces: received byte channel and servo/stepper result channel.
interface cfss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfss_result_if;
  logic       valid;
  logic       ready;
  logic [8:0] servo_value;
  logic       move_valid;
  logic [9:0] move_steps;
  logic       move_back;
  logic       ack_valid;
  modport source (output valid, output servo_value, output move_valid, output move_steps,
                  output move_back, output ack_valid, input ready);
  modport sink   (input valid, input servo_value, input move_valid, input move_steps,
                  input move_back, input ack_valid, output ready);
endinterface

// ----- hw/rtl/cfss_scale.sv -----
// Coordinate scaling: x to servo compare, y to forward step count.
module cfss_scale (
  input  logic [15:0] x_word,
  input  logic [15:0] y_word,
  output logic [8:0]  servo,
  output logic [9:0]  steps
);
  import cfss_pkg::*;

  logic [10:0] x_sat;
  logic [10:0] x_dist;
  logic [29:0] x_prod;
  logic [10:0] y_sat;
  logic [30:0] y_prod;
  logic [9:0]  y_raw;

  always_comb begin
    x_sat  = (x_word > {5'd0, X_FULL}) ? X_FULL : x_word[10:0];
    x_dist = X_FULL - x_sat;
    x_prod = {19'd0, x_dist} * {11'd0, SERVO_RECIP};
    servo  = SERVO_BASE + {3'd0, x_prod[29:24]};

    y_sat  = (y_word > {5'd0, Y_FULL}) ? Y_FULL : y_word[10:0];
    y_prod = {20'd0, y_sat} * {11'd0, STEP_RECIP};
    y_raw  = y_prod[29:20];
    steps  = (y_raw <= STEP_LIMIT) ? y_raw + STEP_OFFSET : y_raw;
  end

endmodule

// ----- hw/rtl/coordinate_frame_to_servo_stepper.sv -----
// Top level: byte-wise frame parser driving servo compare and stepper moves.
//
//   channel | dir | payload                                              | request
//   rx      | in  | rx_byte[7:0]                                         | one byte
//   res     | out | servo_value, move_valid, move_steps, move_back, ack  | one per byte
//
// One byte per cycle sustained while res is not held. Path from rx to res:
// Input register, then parser state and one constant multiply per coordinate into
// the result register. Both stages stall together only while res is held.
// Synchronous reset clears phase, coordinate bytes, last step count; servo to 221.
module coordinate_frame_to_servo_stepper (
  input  logic                 clk,
  input  logic                 rst,
  cfss_byte_if.sink            rx,
  cfss_result_if.source        res
);
  import cfss_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  logic [2:0] phase, phase_next;
  logic [7:0] x_high, x_high_next;
  logic [7:0] y_high, y_high_next;
  logic [9:0] last_steps, last_steps_next;
  logic [8:0] servo_reg, servo_reg_next;

  logic       res_valid;
  logic       mv_next, back_next, ack_next;
  logic [9:0] steps_next;
  logic [8:0] res_servo;
  logic       res_mv, res_back, res_ack;
  logic [9:0] res_steps;

  logic [8:0] servo_calc;
  logic [9:0] steps_calc;

  assign advance  = !res_valid || res.ready;
  assign rx.ready = !s1_valid || advance;

  cfss_scale u_scale (
    .x_word ({x_high, s1_byte}),
    .y_word ({y_high, s1_byte}),
    .servo  (servo_calc),
    .steps  (steps_calc)
  );

  always_comb begin
    phase_next      = phase;
    x_high_next     = x_high;
    y_high_next     = y_high;
    last_steps_next = last_steps;
    servo_reg_next  = servo_reg;
    mv_next         = 1'b0;
    back_next       = 1'b0;
    ack_next        = 1'b0;
    steps_next      = 10'd0;
    case (phase)
      PH_IDLE: begin
        if (s1_byte == START_MARK) begin
          mv_next        = 1'b1;
          back_next      = 1'b1;
          steps_next     = last_steps;
          servo_reg_next = SERVO_BASE;
          phase_next     = PH_X_HI;
        end
      end
      PH_X_HI: begin
        x_high_next = s1_byte;
        phase_next  = PH_X_LO;
      end
      PH_X_LO: begin
        servo_reg_next = servo_calc;
        phase_next     = PH_Y_HI;
      end
      PH_Y_HI: begin
        y_high_next = s1_byte;
        phase_next  = PH_Y_LO;
      end
      PH_Y_LO: begin
        last_steps_next = steps_calc;
        mv_next         = 1'b1;
        steps_next      = steps_calc;
        ack_next        = 1'b1;
        phase_next      = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      x_high     <= 8'd0;
      y_high     <= 8'd0;
      last_steps <= 10'd0;
      servo_reg  <= SERVO_BASE;
      res_valid  <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        phase      <= phase_next;
        x_high     <= x_high_next;
        y_high     <= y_high_next;
        last_steps <= last_steps_next;
        servo_reg  <= servo_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_servo <= servo_reg_next;
      res_mv    <= mv_next;
      res_steps <= steps_next;
      res_back  <= back_next;
      res_ack   <= ack_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.servo_value = res_servo;
  assign res.move_valid  = res_mv;
  assign res.move_steps  = res_steps;
  assign res.move_back   = res_back;
  assign res.ack_valid   = res_ack;

endmodule

// ----- hw/rtl/cfss_checker.sv -----
// Port-level checker for the coordinate frame block, bound to the top level.
module cfss_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [8:0] servo_value,
  input logic       move_valid,
  input logic [9:0] move_steps,
  input logic       move_back,
  input logic       ack_valid
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(servo_value) && $stable(move_steps)
      && $stable(move_valid) && $stable(move_back) && $stable(ack_valid))
    else $error("result changed while stalled");

  a_ack_fwd: assert property (@(posedge clk) disable iff (rst)
    res_valid && ack_valid |-> move_valid && !move_back)
    else $error("acknowledge without forward move");

  a_no_move: assert property (@(posedge clk) disable iff (rst)
    res_valid && !move_valid |-> move_steps == 10'd0 && !move_back && !ack_valid)
    else $error("move fields set without move");

  a_servo_rng: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> servo_value >= 9'd221 && servo_value <= 9'd268)
    else $error("servo value out of range");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind coordinate_frame_to_servo_stepper cfss_checker u_cfss_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .servo_value (res.servo_value),
  .move_valid  (res.move_valid),
  .move_steps  (res.move_steps),
  .move_back   (res.move_back),
  .ack_valid   (res.ack_valid)
);

// ----- test/coordinate_frame_to_servo_stepper_tb.sv -----
// Testbench: frame parser driving servo compare and stepper moves, checked against a predictor.
`timescale 1ns / 1ps

module coordinate_frame_to_servo_stepper_tb;
  import cfss_pkg::*;

  localparam int unsigned SERVO_SPAN  = 47;
  localparam int unsigned STEP_FULL   = 730;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RAND_ITEMS  = 900;

  typedef struct packed {
    logic [8:0] servo;
    logic       mv;
    logic [9:0] steps;
    logic       back;
    logic       ack;
  } servo_cmd_t;

  logic clk;
  logic rst;

  cfss_byte_if   rx_if ();
  cfss_result_if res_if ();

  coordinate_frame_to_servo_stepper u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if)
  );

  // predictor state
  logic [2:0] frame_phase;
  logic [7:0] x_hi_byte;
  logic [7:0] y_hi_byte;
  logic [9:0] fwd_steps;
  logic [8:0] servo_now;

  servo_cmd_t cmd_q[$];
  servo_cmd_t want;
  int         errors;
  int         cycles;
  int         hold_req;
  int         rx_stall_left;
  bit         quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run timed out", $time);
      $display("** coordinate_frame_to_servo_stepper: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic servo_cmd_t parse_frame_byte(logic [7:0] b);
    servo_cmd_t  c;
    int unsigned v;
    c = '0;
    case (frame_phase)
      PH_IDLE: begin
        if (b == START_MARK) begin
          c.mv        = 1'b1;
          c.back      = 1'b1;
          c.steps     = fwd_steps;
          servo_now   = SERVO_BASE;
          frame_phase = PH_X_HI;
        end
      end
      PH_X_HI: begin
        x_hi_byte   = b;
        frame_phase = PH_X_LO;
      end
      PH_X_LO: begin
        v = {x_hi_byte, b};
        if (v > X_FULL) v = X_FULL;
        servo_now   = 9'(int'(SERVO_BASE) + ((int'(X_FULL) - v) * SERVO_SPAN) / int'(X_FULL));
        frame_phase = PH_Y_HI;
      end
      PH_Y_HI: begin
        y_hi_byte   = b;
        frame_phase = PH_Y_LO;
      end
      PH_Y_LO: begin
        v = {y_hi_byte, b};
        if (v > Y_FULL) v = Y_FULL;
        v = (v * STEP_FULL) / int'(Y_FULL);
        if (v <= STEP_LIMIT) v += STEP_OFFSET;
        fwd_steps   = 10'(v);
        c.mv        = 1'b1;
        c.steps     = fwd_steps;
        c.ack       = 1'b1;
        frame_phase = PH_IDLE;
      end
      default: frame_phase = PH_IDLE;
    endcase
    c.servo = servo_now;
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    cmd_q.push_back(parse_frame_byte(b));
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] x, input logic [15:0] y);
    send_byte(START_MARK);
    send_byte(x[15:8]);
    send_byte(x[7:0]);
    send_byte(y[15:8]);
    send_byte(y[7:0]);
  endtask

  function automatic logic [15:0] pick_coord(int full);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, full));
    if (r < 85) return 16'($urandom_range(full + 1, full + 400));
    return 16'($urandom_range(0, 65535));
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    res_if.ready  = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        rx_stall_left = hold_req;
        hold_req      = 0;
      end
      if (rst) begin
        res_if.ready = 1'b0;
      end else if (rx_stall_left > 0) begin
        res_if.ready = 1'b0;
        rx_stall_left--;
      end else begin
        res_if.ready  = 1'b1;
        rx_stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
      end else begin
        want = cmd_q.pop_front();
        check_field("servo_value", want.servo, res_if.servo_value);
        check_field("move_valid",  want.mv,    res_if.move_valid);
        check_field("move_steps",  want.steps, res_if.move_steps);
        check_field("move_back",   want.back,  res_if.move_back);
        check_field("ack_valid",   want.ack,   res_if.ack_valid);
      end
    end
  end

  task automatic test_directed();
    // idle noise, then marker with no earlier frame: backward move of 0
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_frame(16'h0000, 16'h0000);
    // marker bytes as data, both coordinates saturated
    send_frame(16'hFFFF, 16'hFFFF);
    // x at full scale, y just above the offset threshold
    send_frame(16'd1920, 16'd924);
    // x one past full scale, y at the threshold
    send_frame(16'd1921, 16'd922);
    send_byte(8'hFE);
    send_byte(START_MARK);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    repeat (40) send_frame(pick_coord(1920), pick_coord(1080));
    quiet = 1'b0;
  endtask

  task automatic test_back_pressure();
    quiet    = 1'b1;
    hold_req = 300;
    repeat (40) send_frame(pick_coord(1920), pick_coord(1080));
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 254)));
      end
      if ($urandom_range(0, 99) < 10) quiet = ~quiet;
      send_frame(pick_coord(1920), pick_coord(1080));
      sent += 5;
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors        = 0;
    cycles        = 0;
    hold_req      = 0;
    quiet         = 1'b0;
    frame_phase   = PH_IDLE;
    x_hi_byte     = '0;
    y_hi_byte     = '0;
    fwd_steps     = '0;
    servo_now     = SERVO_BASE;
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_rate();
    test_back_pressure();
    test_random();

    rx_if.valid = 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** coordinate_frame_to_servo_stepper: PASSED **");
    end else begin
      $display("** coordinate_frame_to_servo_stepper: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cfss_pkg.sv
hw/rtl/cfss_if.sv
hw/rtl/cfss_scale.sv
hw/rtl/coordinate_frame_to_servo_stepper.sv
hw/rtl/cfss_checker.sv
test/coordinate_frame_to_servo_stepper_tb.sv
